// ===== hdl/lgrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life row stencil package
// Shared widths, reset values and rule counts for the row stencil block.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int ROW_BITS          = 64;  // payload width of a row word
    localparam int CFG_BITS          = 7;   // width of the row_width register
    localparam int MAX_WIDTH_DEFAULT = 64;  // widest grid the block handles
    localparam int COUNT_BITS        = 4;   // holds a neighbor count of 0..8

    localparam logic [CFG_BITS-1:0]   ROW_WIDTH_RESET = 7'd64;
    localparam logic [COUNT_BITS-1:0] BIRTH_COUNT     = 4'd3;
    localparam logic [COUNT_BITS-1:0] SURVIVE_COUNT   = 4'd2;

endpackage

`default_nettype wire

// ===== hdl/lgrs_grid_row_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid row channel
// Valid/ready channel carrying one current-generation row word.
// ----------------------------------------------------------------------------
interface lgrs_grid_row_if;

    logic                          valid;
    logic                          ready;
    logic [lgrs_pkg::ROW_BITS-1:0] row_bits;
    logic                          last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);

endinterface

`default_nettype wire

// ===== hdl/lgrs_next_row_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next row channel
// Valid/ready channel carrying one next-generation row word.
// ----------------------------------------------------------------------------
interface lgrs_next_row_if;

    logic                          valid;
    logic                          ready;
    logic [lgrs_pkg::ROW_BITS-1:0] next_row_bits;
    logic                          frame_end;

    modport source (output valid, output next_row_bits, output frame_end, input ready);
    modport sink   (input valid, input next_row_bits, input frame_end, output ready);

endinterface

`default_nettype wire

// ===== hdl/life_generation_row_stencil_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life generation row stencil unit
// One B3/S23 generation over a grid that streams in one row word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   grid_row carries the current generation, one row per word, bit k is
//   column k; last_row marks the final row of a grid. next_row returns the
//   next generation one row behind: the first row of a grid gives no word,
//   each later row gives the updated row above it, and the last row also
//   gives itself with frame_end set. Grid edges pass through unchanged and
//   bits at and above row_width (zero counts as one) read as zero.
//   cfg_wr_en/cfg_wr_data write row_width; write it only while the block is
//   idle. Reset sets row_width to 64 and starts a fresh grid.
// Timing:
//   A row word enters the stage register at its accept edge; the neighbor
//   count and rule run from the stage into the output register, which
//   drives next_row. One row per cycle is taken while next_row keeps up,
//   except after a row marked last that is not first in its grid: it holds
//   two results in the stage and blocks the next row while the second
//   result drains through the single output register.
//   When next_row stalls, the output register holds its word, the stage
//   holds its pending results and grid_row.ready drops once both are full.
// ----------------------------------------------------------------------------
module life_generation_row_stencil_unit
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_BITS-1:0] cfg_wr_data,
    lgrs_grid_row_if.sink            grid_row,
    lgrs_next_row_if.source          next_row
);

    // configuration
    logic [CFG_BITS-1:0]  row_width_reg;
    logic [CFG_BITS-1:0]  eff_width;
    logic [MAX_WIDTH-1:0] width_mask;
    logic [MAX_WIDTH-1:0] inner_mask;

    // row history
    logic [MAX_WIDTH-1:0] row_above_reg;
    logic [MAX_WIDTH-1:0] row_center_reg;
    logic [1:0]           rows_seen_reg;
    logic [1:0]           rows_seen_next;

    // stage register: the three rows and the results still owed
    logic [MAX_WIDTH-1:0] up_reg;
    logic [MAX_WIDTH-1:0] mid_reg;
    logic [MAX_WIDTH-1:0] cur_reg;
    logic                 a_pend_reg;   // updated or passed row above
    logic                 a_life_reg;   // apply the rule to it
    logic                 b_pend_reg;   // last row echo
    logic                 a_pend_next;
    logic                 b_pend_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ROW_BITS-1:0]  out_bits_reg;
    logic [ROW_BITS-1:0]  out_bits_next;
    logic                 out_end_reg;
    logic                 out_end_next;

    logic                 out_free;
    logic                 stage_busy;
    logic                 accept;
    logic [MAX_WIDTH-1:0] cur_masked;
    logic [MAX_WIDTH-1:0] life_bits;
    logic [MAX_WIDTH-1:0] a_bits;

    // ------------------------------------------------------------------
    // Effective width and column masks
    // ------------------------------------------------------------------
    always_comb
    begin
        if (row_width_reg == '0)
            eff_width = CFG_BITS'(1);
        else if (row_width_reg > CFG_BITS'(MAX_WIDTH))
            eff_width = CFG_BITS'(MAX_WIDTH);
        else
            eff_width = row_width_reg;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            width_mask[k] = (CFG_BITS'(k) < eff_width);
            inner_mask[k] = (k >= 1) && (CFG_BITS'(k + 1) < eff_width);
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || next_row.ready;
    assign stage_busy = a_pend_reg || b_pend_reg;
    // take a row when the stage is empty, or when its only result leaves now
    assign grid_row.ready = !stage_busy || (out_free && !(a_pend_reg && b_pend_reg));
    assign accept     = grid_row.valid && grid_row.ready;
    assign cur_masked = grid_row.row_bits[MAX_WIDTH-1:0] & width_mask;

    // ------------------------------------------------------------------
    // Row history and grid position
    // ------------------------------------------------------------------
    always_comb
    begin
        if (grid_row.last_row)
            rows_seen_next = 2'd0;
        else if (rows_seen_reg == 2'd2)
            rows_seen_next = 2'd2;
        else
            rows_seen_next = rows_seen_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RESET;
            row_above_reg  <= '0;
            row_center_reg <= '0;
            rows_seen_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                row_width_reg <= cfg_wr_data;
            if (accept)
            begin
                row_above_reg  <= row_center_reg;
                row_center_reg <= cur_masked;
                rows_seen_reg  <= rows_seen_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage register: load on accept, retire one result per free output
    // ------------------------------------------------------------------
    always_comb
    begin
        a_pend_next = a_pend_reg;
        b_pend_next = b_pend_reg;
        if (out_free)
        begin
            if (a_pend_reg)
                a_pend_next = 1'b0;
            else
                b_pend_next = 1'b0;
        end
        if (accept)
        begin
            a_pend_next = (rows_seen_reg != 2'd0);
            b_pend_next = grid_row.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
        end
        else
        begin
            a_pend_reg <= a_pend_next;
            b_pend_reg <= b_pend_next;
        end
    end

    // stored rows are masked again with the width in force for this row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg     <= row_above_reg & width_mask;
            mid_reg    <= row_center_reg & width_mask;
            cur_reg    <= cur_masked;
            a_life_reg <= (rows_seen_reg == 2'd2);
        end
    end

    // ------------------------------------------------------------------
    // Rule: count the eight neighbors of every column, edges read as dead
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [COUNT_BITS-1:0] n;
        logic                  ul, ur, ml, mr, dl, dr;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            ul = (c > 0) ? up_reg[(c > 0) ? c - 1 : 0] : 1'b0;
            ml = (c > 0) ? mid_reg[(c > 0) ? c - 1 : 0] : 1'b0;
            dl = (c > 0) ? cur_reg[(c > 0) ? c - 1 : 0] : 1'b0;
            ur = (c < MAX_WIDTH - 1) ? up_reg[(c < MAX_WIDTH - 1) ? c + 1 : c] : 1'b0;
            mr = (c < MAX_WIDTH - 1) ? mid_reg[(c < MAX_WIDTH - 1) ? c + 1 : c] : 1'b0;
            dr = (c < MAX_WIDTH - 1) ? cur_reg[(c < MAX_WIDTH - 1) ? c + 1 : c] : 1'b0;
            n  = COUNT_BITS'(ul) + COUNT_BITS'(up_reg[c]) + COUNT_BITS'(ur)
               + COUNT_BITS'(ml) + COUNT_BITS'(mr)
               + COUNT_BITS'(dl) + COUNT_BITS'(cur_reg[c]) + COUNT_BITS'(dr);
            life_bits[c] = (n == BIRTH_COUNT) || (mid_reg[c] && (n == SURVIVE_COUNT));
        end
    end

    // edge columns keep the middle row; everything is clipped to the width
    assign a_bits = a_life_reg
                  ? (((mid_reg & ~inner_mask) | (life_bits & inner_mask)) & width_mask)
                  : mid_reg;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bits_next  = out_bits_reg;
        out_end_next   = out_end_reg;
        if (out_free)
        begin
            out_valid_next = stage_busy;
            if (a_pend_reg)
            begin
                out_bits_next = ROW_BITS'(a_bits);
                out_end_next  = 1'b0;
            end
            else
            begin
                out_bits_next = ROW_BITS'(cur_reg);
                out_end_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_bits_reg <= out_bits_next;
        out_end_reg  <= out_end_next;
    end

    assign next_row.valid         = out_valid_reg;
    assign next_row.next_row_bits = out_bits_reg;
    assign next_row.frame_end     = out_end_reg;

`ifndef SYNTHESIS
    // both results of a last row outstanding: no room for another row
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_pend_reg && b_pend_reg) |-> !grid_row.ready)
        else $error("row taken while stage holds two results");

    // a pending result is never dropped while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_pend_reg && !out_free) |=> a_pend_reg)
        else $error("pending row result lost under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_pend_reg && !out_free) |=> b_pend_reg)
        else $error("pending last row echo lost under stall");

    // the row count saturates at two
    assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg != 2'd3)
        else $error("row count beyond saturation");
`endif

endmodule

`default_nettype wire

// ===== tb/lgrs_generation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation checker
// Watches the row and result channels, predicts each next-generation word
// and compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module lgrs_generation_checker
    import lgrs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_BITS-1:0] cfg_wr_data,
    lgrs_grid_row_if                 grid_row,
    lgrs_next_row_if                 next_row,
    output int                       mismatch_count,
    output int                       words_outstanding,
    output int                       rows_taken,
    output int                       words_checked
);

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_bits;
        logic                frame_end;
    } next_word_t;

    next_word_t          expected_words[$];
    logic [ROW_BITS-1:0] row_above;
    logic [ROW_BITS-1:0] row_center;
    int                  rows_in_grid;
    logic [CFG_BITS-1:0] row_width;
    int                  errors;
    int                  taken;
    int                  checked;

    // Zero and oversized settings clamp to the usable range.
    function automatic int effective_width(input logic [CFG_BITS-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > MAX_WIDTH_DEFAULT)
            return MAX_WIDTH_DEFAULT;
        return int'(value);
    endfunction

    function automatic logic [ROW_BITS-1:0] width_mask(input int w);
        logic [ROW_BITS-1:0] ones;
        ones = '1;
        return ~(ones << w);
    endfunction

    // B3/S23 over interior columns; column 0 and column w-1 keep their value.
    function automatic logic [ROW_BITS-1:0] evolve_row(input logic [ROW_BITS-1:0] up,
                                                      input logic [ROW_BITS-1:0] mid,
                                                      input logic [ROW_BITS-1:0] down,
                                                      input int w);
        logic [ROW_BITS-1:0] evolved;
        int                  n;
        evolved = mid;
        for (int c = 1; c + 1 < w; c++)
        begin
            n = 0;
            for (int d = -1; d <= 1; d++)
                n += up[c+d] + down[c+d];
            n += mid[c-1] + mid[c+1];
            evolved[c] = mid[c] ? (n == SURVIVE_COUNT || n == BIRTH_COUNT)
                                : (n == BIRTH_COUNT);
        end
        return evolved;
    endfunction

    function automatic void push_result(input logic [ROW_BITS-1:0] bits, input logic fe);
        next_word_t word;
        word.row_bits  = bits;
        word.frame_end = fe;
        expected_words.push_back(word);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int                  w;
        logic [ROW_BITS-1:0] m;
        logic [ROW_BITS-1:0] cur;
        next_word_t          want;
        if (!rst_n)
        begin
            expected_words.delete();
            row_above    = '0;
            row_center   = '0;
            rows_in_grid = 0;
            row_width    = ROW_WIDTH_RESET;
            errors       = 0;
            taken        = 0;
            checked      = 0;
        end
        else
        begin
            if (cfg_wr_en)
                row_width = cfg_wr_data;

            // Retire the oldest expectation before adding new ones.
            if (next_row.valid && next_row.ready)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected word: expected none, actual %h frame_end %b",
                                 $time, next_row.next_row_bits, next_row.frame_end);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (next_row.next_row_bits !== want.row_bits)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: next_row_bits mismatch: expected %h, actual %h",
                                     $time, want.row_bits, next_row.next_row_bits);
                    end
                    if (next_row.frame_end !== want.frame_end)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: frame_end mismatch: expected %b, actual %b",
                                     $time, want.frame_end, next_row.frame_end);
                    end
                end
            end

            if (grid_row.valid && grid_row.ready)
            begin
                taken++;
                w   = effective_width(row_width);
                m   = width_mask(w);
                cur = grid_row.row_bits & m;
                if (rows_in_grid == 1)
                    push_result(row_center & m, 1'b0);
                else if (rows_in_grid >= 2)
                    push_result(evolve_row(row_above & m, row_center & m, cur, w) & m, 1'b0);
                row_above  = row_center;
                row_center = cur;
                if (rows_in_grid < 2)
                    rows_in_grid++;
                if (grid_row.last_row)
                begin
                    push_result(cur, 1'b1);
                    rows_in_grid = 0;
                end
            end
        end
        mismatch_count    <= errors;
        words_outstanding <= expected_words.size();
        rows_taken        <= taken;
        words_checked     <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation row stencil testbench
// Streams directed and random grids through the stencil unit over a range of
// row widths, with random idling on both channels; the checker predicts and
// compares every next-generation word.
// ----------------------------------------------------------------------------
module tb_top;
    import lgrs_pkg::*;

    localparam int RANDOM_PHASES  = 12;
    localparam int ROWS_PER_PHASE = 98;
    localparam int LONG_STALL     = 400;  // cycles the result side holds off once
    localparam int SETTLE_CYCLES  = 4;    // stage and output register drain plus margin
    localparam int TAIL_CYCLES    = 8;

    // Extremes of the width register visited first, random settings after.
    localparam logic [CFG_BITS-1:0] WIDTH_PLAN [9] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd63, 7'd64, 7'd65, 7'd127
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_BITS-1:0] cfg_wr_data;

    lgrs_grid_row_if grid_row ();
    lgrs_next_row_if next_row ();

    int   mismatch_count;
    int   words_outstanding;
    int   rows_taken;
    int   words_checked;
    int   rows_sent = 0;
    int   width_writes = 0;
    logic tx_gaps_on = 1'b1;
    logic rx_gaps_on = 1'b1;
    logic long_stall_req = 1'b0;

    always #1 clk = ~clk;

    life_generation_row_stencil_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .grid_row    (grid_row),
        .next_row    (next_row)
    );

    lgrs_generation_checker i_generation_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .grid_row          (grid_row),
        .next_row          (next_row),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .rows_taken        (rows_taken),
        .words_checked     (words_checked)
    );

    // Mix sparse, dense and half-filled rows so that births, survivals and
    // deaths all show up; bits above the width are random too.
    function automatic logic [ROW_BITS-1:0] random_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return a & b;
            1:       return a | b;
            default: return a;
        endcase
    endfunction

    // Mostly mid-sized grids, with single-row and two-row grids now and then.
    function automatic int grid_height();
        case ($urandom_range(0, 7))
            0:       return 1;
            1:       return 2;
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    // Offer one row word and hold it until the block takes it. Keep valid
    // high across back-to-back words; drop it only for an idle gap.
    task automatic send_row(input logic [ROW_BITS-1:0] bits, input logic last);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            grid_row.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        grid_row.valid    <= 1'b1;
        grid_row.row_bits <= bits;
        grid_row.last_row <= last;
        do @(posedge clk); while (!grid_row.ready);
        rows_sent++;
    endtask

    // Stop offering, wait until every row is taken and every expected word
    // is back, then let the stage settle so a width write finds it idle.
    task automatic drain_and_settle();
        grid_row.valid <= 1'b0;
        do @(posedge clk); while (rows_taken != rows_sent || words_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        width_writes++;
    endtask

    // Result side: draw an idle gap per word, and once on request hold off
    // for a long stretch so the block fills up and stalls the row side.
    initial
    begin : result_side
        int gap;
        next_row.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                next_row.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                long_stall_req = 1'b0;
            end
            gap = (rx_gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, 15) : 0;
            if (gap > 0)
            begin
                next_row.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            next_row.ready <= 1'b1;
            do @(posedge clk); while (!next_row.valid);
        end
    end

    initial
    begin : stimulus
        int height;
        int phase_start;
        logic [CFG_BITS-1:0] phase_width;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        grid_row.valid    <= 1'b0;
        grid_row.row_bits <= '0;
        grid_row.last_row <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, full width from reset: a single-row grid, a two-row
        // grid with edge bits, and a blinker beside set edge columns.
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_row(64'h0000_0000_0000_0000, 1'b0);
        send_row(64'h0000_0000_0000_0400, 1'b0);
        send_row(64'h0000_0000_0000_0400, 1'b0);
        send_row(64'h8000_0000_0000_0401, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        drain_and_settle();

        // Zero width clamps to one column, which passes unchanged.
        write_width(7'd0);
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_row(random_row(), 1'b0);
        send_row(64'h0000_0000_0000_0000, 1'b1);
        drain_and_settle();

        // Oversized width clamps to the full row; top columns are active.
        write_width(7'd127);
        send_row(64'hE000_0000_0000_0007, 1'b0);
        send_row(64'hE000_0000_0000_0007, 1'b0);
        send_row(64'hE000_0000_0000_0007, 1'b1);
        drain_and_settle();

        // Three columns leave a single interior cell.
        write_width(7'd3);
        send_row(64'h0000_0000_0000_0007, 1'b0);
        send_row(64'h0000_0000_0000_0002, 1'b0);
        send_row(64'h0000_0000_0000_0005, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        drain_and_settle();

        // Two columns have no interior at all.
        write_width(7'd2);
        send_row(random_row(), 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_row(random_row(), 1'b1);
        drain_and_settle();

        // Change the width in mid-grid: stored rows keep their old masking.
        write_width(7'd5);
        send_row(64'hFFFF_FFFF_FFFF_FF1F, 1'b0);
        send_row(64'h0000_0000_0000_000E, 1'b0);
        drain_and_settle();
        write_width(7'd64);
        send_row(64'hFFFF_FFFF_0000_00E0, 1'b0);
        send_row(64'h0000_0000_0000_0000, 1'b1);
        drain_and_settle();

        // Random part: one width per phase, random grid heights and contents,
        // idling switched per side so some phases run back to back.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            phase_width = (p < 9) ? WIDTH_PLAN[p] : CFG_BITS'($urandom_range(0, 127));
            write_width(phase_width);
            tx_gaps_on = ($urandom_range(0, 2) != 0);
            rx_gaps_on = ($urandom_range(0, 2) != 0);
            if (p == 1)
            begin
                // Keep rows coming while the result side holds off.
                tx_gaps_on     = 1'b0;
                long_stall_req = 1'b1;
            end
            phase_start = rows_sent;
            while (rows_sent - phase_start < ROWS_PER_PHASE)
            begin
                height = grid_height();
                for (int r = 0; r < height; r++)
                    send_row(random_row(), r == height - 1);
            end
            // Sometimes leave a grid open so the next width lands mid-grid.
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_row(random_row(), 1'b0);
            drain_and_settle();
        end

        // Catch any stray word after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d rows and checked %0d result words over %0d width settings,",
                 rows_sent, words_checked, width_writes);
        $display("%s %0d-cycle result stall.",
                 "including clamped widths, short grids, mid-grid width changes and a",
                 LONG_STALL);
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Hard limit, several times the slowest legal run.
    initial
    begin : watchdog
        #1000000;
        $display("Timeout with %0d rows sent, %0d taken, %0d words still expected",
                 rows_sent, rows_taken, words_outstanding);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lgrs_pkg.sv
hdl/lgrs_grid_row_if.sv
hdl/lgrs_next_row_if.sv
hdl/life_generation_row_stencil_unit.sv
tb/lgrs_generation_checker.sv
tb/tb_top.sv
